@@ rtl/uart_rb_pkg.sv @@
// ----------------------------------------------------------------------------
// UART register block package
// Sizes, register codes and bit masks shared by the UART register block.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

    localparam int FIFO_DEPTH    = 64;
    localparam int BACKOFF_LIMIT = 16;
    localparam int PAGE_BYTES    = 4096;

    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int BACKOFF_W = $clog2(BACKOFF_LIMIT + 1);

    localparam int OFFSET_W  = 12;
    localparam int LEN_W     = 4;
    localparam int SUM_W     = (OFFSET_W + 1 > $clog2(PAGE_BYTES + 1)) ?
                               OFFSET_W + 1 : $clog2(PAGE_BYTES + 1);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        REG_DATA   = 3'd0,
        REG_IER    = 3'd1,
        REG_IIR    = 3'd2,
        REG_LCR    = 3'd3,
        REG_MCR    = 3'd4,
        REG_LSR    = 3'd5,
        REG_MSR    = 3'd6,
        REG_SCRATCH = 3'd7
    } t_reg_idx;

    localparam logic CFG_REG_SHIFT    = 1'b0;
    localparam logic CFG_ACCESS_WIDTH = 1'b1;

    localparam logic [7:0] LSR_DR       = 8'h01;
    localparam logic [7:0] LSR_BI       = 8'h10;
    localparam logic [7:0] LSR_TX_EMPTY = 8'h60;
    localparam logic [7:0] MSR_FIXED    = 8'hB0;
    localparam logic [7:0] IIR_FIXED    = 8'hC0;

    localparam logic [3:0] IID_RX   = 4'h4;
    localparam logic [3:0] IID_THRE = 4'h2;
    localparam logic [3:0] IID_NONE = 4'h1;

    localparam logic [7:0] MCR_RESET = 8'h08;
    localparam logic [7:0] DLL_RESET = 8'h0C;

endpackage

@@ rtl/uart_register_block_top.sv @@
// ----------------------------------------------------------------------------
// UART register block
// 16550-style register file with a receive FIFO, loopback and host polling.
// ----------------------------------------------------------------------------
// Every request (bus read, bus write or tick) is handled combinationally, and
// a new request can be taken in every cycle while the output is empty or
// being accepted; the result is registered in the output register at the
// input transfer and is held until the output transfer. The receive FIFO is a
// memory with a registered read port kept pointed at the head entry, so a data
// read returns its byte in the same cycle. FIFO entries are not cleared at reset.
module uart_register_block_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Fields from bit 0: offset[12], access_len[4], wdata[8], host_valid[1],
    // host_byte[8], zero fill.
    input  logic [uart_rb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: req_type[2].
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: ok[1], rdata[8], irq[1], tx_valid[1], tx_data[8],
    // host_taken[1], zero fill.
    output logic [uart_rb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [uart_rb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import uart_rb_pkg::*;

    logic [7:0]           r_fifo_mem [FIFO_DEPTH];
    logic [7:0]           r_head_data;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [3:0]           r_ier, n_ier;
    logic [7:0]           r_lcr, n_lcr;
    logic [7:0]           r_mcr, n_mcr;
    logic [7:0]           r_fcr, n_fcr;
    logic [7:0]           r_dll, n_dll;
    logic [7:0]           r_dlm, n_dlm;
    logic [7:0]           r_scr, n_scr;
    logic [7:0]           r_lsr, n_lsr;
    logic [3:0]           r_iir, n_iir;
    logic [BACKOFF_W-1:0] r_backoff, n_backoff;
    logic                 r_irq, n_irq;
    logic [1:0]           r_reg_shift;
    logic [3:0]           r_access_width;

    logic                 r_out_valid;
    logic                 r_ok, n_ok;
    logic [7:0]           r_rdata, n_rdata;
    logic                 r_tx_valid, n_tx_valid;
    logic [7:0]           r_tx_data, n_tx_data;
    logic                 r_taken, n_taken;

    logic [OFFSET_W-1:0]  in_offset;
    logic [LEN_W-1:0]     in_len;
    logic [7:0]           in_wdata;
    logic                 in_host_valid;
    logic [7:0]           in_host_byte;
    logic                 fire;
    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic [7:0]           wr_data;
    logic [PTR_W-1:0]     rd_addr;
    logic [CNT_W:0]       push_sum;
    logic                 do_refresh;
    logic                 dlab;
    logic [SUM_W-1:0]     end_addr;
    logic [OFFSET_W-1:0]  shifted_off;
    t_reg_idx             idx;
    logic                 cfg_write;

    assign in_offset     = s_axis_tdata[11:0];
    assign in_len        = s_axis_tdata[15:12];
    assign in_wdata      = s_axis_tdata[23:16];
    assign in_host_valid = s_axis_tdata[24];
    assign in_host_byte  = s_axis_tdata[32:25];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;

    assign dlab        = r_lcr[7];
    assign end_addr    = SUM_W'(in_offset) + SUM_W'(in_len);
    assign shifted_off = in_offset >> r_reg_shift;
    assign idx         = t_reg_idx'(shifted_off[2:0]);
    assign push_sum    = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count);

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_ier      = r_ier;
        n_lcr      = r_lcr;
        n_mcr      = r_mcr;
        n_fcr      = r_fcr;
        n_dll      = r_dll;
        n_dlm      = r_dlm;
        n_scr      = r_scr;
        n_lsr      = r_lsr;
        n_iir      = r_iir;
        n_backoff  = r_backoff;
        n_irq      = r_irq;
        n_ok       = 1'b0;
        n_rdata    = 8'h00;
        n_tx_valid = 1'b0;
        n_tx_data  = 8'h00;
        n_taken    = 1'b0;
        wr_en      = 1'b0;
        wr_data    = in_wdata;
        do_refresh = 1'b0;
        wr_addr    = (push_sum >= (CNT_W + 1)'(FIFO_DEPTH)) ?
                     PTR_W'(push_sum - (CNT_W + 1)'(FIFO_DEPTH)) : PTR_W'(push_sum);

        case (t_req'(s_axis_tuser))
            REQ_READ, REQ_WRITE: begin
                if (in_len == r_access_width && end_addr <= SUM_W'(PAGE_BYTES)) begin
                    n_ok = 1'b1;
                    if (t_req'(s_axis_tuser) == REQ_READ) begin
                        case (idx)
                            REG_DATA: begin
                                do_refresh = 1'b1;
                                if (dlab) begin
                                    n_rdata = r_dll;
                                end else if (r_count == '0) begin
                                    n_lsr = n_lsr & ~LSR_DR;
                                end else if ((r_lsr & LSR_BI) != 8'h00) begin
                                    n_lsr = n_lsr & ~LSR_BI;
                                end else begin
                                    n_rdata = r_head_data;
                                    n_head  = (r_head == PTR_W'(FIFO_DEPTH - 1)) ?
                                              '0 : r_head + 1'b1;
                                    n_count = r_count - 1'b1;
                                    if (n_count == '0) begin
                                        n_lsr = n_lsr & ~LSR_DR;
                                    end
                                end
                            end
                            REG_IER: n_rdata = dlab ? r_dlm : {4'h0, r_ier};
                            REG_IIR: n_rdata = IIR_FIXED | {4'h0, r_iir};
                            REG_LCR: n_rdata = r_lcr;
                            REG_MCR: n_rdata = r_mcr;
                            REG_LSR: n_rdata = r_lsr;
                            REG_MSR: n_rdata = MSR_FIXED;
                            default: n_rdata = r_scr;
                        endcase
                    end else begin
                        case (idx)
                            REG_DATA: begin
                                do_refresh = 1'b1;
                                if (dlab) begin
                                    n_dll = in_wdata;
                                end else if (r_mcr[4]) begin
                                    if (r_count < CNT_W'(FIFO_DEPTH)) begin
                                        wr_en   = 1'b1;
                                        n_count = r_count + 1'b1;
                                        n_lsr   = n_lsr | LSR_DR;
                                    end
                                end else begin
                                    n_lsr      = n_lsr | LSR_TX_EMPTY;
                                    n_tx_valid = 1'b1;
                                    n_tx_data  = in_wdata;
                                end
                            end
                            REG_IER: begin
                                do_refresh = 1'b1;
                                if (dlab) begin
                                    n_dlm = in_wdata;
                                end else begin
                                    n_ier = in_wdata[3:0];
                                end
                            end
                            REG_IIR: begin
                                do_refresh = 1'b1;
                                n_fcr = in_wdata;
                            end
                            REG_LCR: begin
                                do_refresh = 1'b1;
                                n_lcr = in_wdata;
                            end
                            REG_MCR: begin
                                do_refresh = 1'b1;
                                n_mcr = in_wdata;
                            end
                            REG_SCRATCH: n_scr = in_wdata;
                            default: ;
                        endcase
                    end
                end
            end
            REQ_TICK: begin
                if (r_fcr[0] && !r_mcr[4] && r_count < CNT_W'(FIFO_DEPTH)) begin
                    if (r_backoff != '0 && r_backoff < BACKOFF_W'(BACKOFF_LIMIT)) begin
                        n_backoff = r_backoff + 1'b1;
                    end else if (!in_host_valid) begin
                        n_backoff = BACKOFF_W'(1);
                    end else begin
                        n_backoff  = '0;
                        wr_en      = 1'b1;
                        wr_data    = in_host_byte;
                        n_count    = r_count + 1'b1;
                        n_lsr      = n_lsr | LSR_DR;
                        n_taken    = 1'b1;
                        do_refresh = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (do_refresh) begin
            if (n_fcr[1]) begin
                n_fcr[1] = 1'b0;
                n_head   = '0;
                n_count  = '0;
                n_lsr    = n_lsr & ~LSR_DR;
            end
            if (n_fcr[2]) begin
                n_fcr[2] = 1'b0;
                n_lsr    = n_lsr | LSR_TX_EMPTY;
            end
            if (n_ier[0] && n_lsr[0]) begin
                n_iir = IID_RX;
            end else if (n_ier[1] && n_lsr[6]) begin
                n_iir = IID_THRE;
            end else begin
                n_iir = IID_NONE;
            end
            n_irq = (n_iir != IID_NONE);
            if (!n_ier[1]) begin
                n_lsr = n_lsr | LSR_TX_EMPTY;
            end
        end
    end

    assign rd_addr = fire ? n_head : r_head;

    always_ff @(posedge i_clk) begin
        if (fire && wr_en) begin
            r_fifo_mem[wr_addr] <= wr_data;
        end
        if (fire && wr_en && wr_addr == rd_addr) begin
            r_head_data <= wr_data;
        end else begin
            r_head_data <= r_fifo_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_ier       <= 4'h0;
            r_lcr       <= 8'h00;
            r_mcr       <= MCR_RESET;
            r_fcr       <= 8'h00;
            r_dll       <= DLL_RESET;
            r_dlm       <= 8'h00;
            r_scr       <= 8'h00;
            r_lsr       <= LSR_TX_EMPTY;
            r_iir       <= IID_NONE;
            r_backoff   <= '0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_head    <= n_head;
                r_count   <= n_count;
                r_ier     <= n_ier;
                r_lcr     <= n_lcr;
                r_mcr     <= n_mcr;
                r_fcr     <= n_fcr;
                r_dll     <= n_dll;
                r_dlm     <= n_dlm;
                r_scr     <= n_scr;
                r_lsr     <= n_lsr;
                r_iir     <= n_iir;
                r_backoff <= n_backoff;
                r_irq     <= n_irq;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ok       <= n_ok;
            r_rdata    <= n_rdata;
            r_tx_valid <= n_tx_valid;
            r_tx_data  <= n_tx_data;
            r_taken    <= n_taken;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_taken, r_tx_data, r_tx_valid, r_irq, r_rdata, r_ok};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_shift    <= 2'd0;
            r_access_width <= 4'd1;
        end else if (cfg_write) begin
            case (paddr[2])
                CFG_REG_SHIFT:    r_reg_shift    <= pwdata[1:0];
                CFG_ACCESS_WIDTH: r_access_width <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_REG_SHIFT:    prdata = {30'h0, r_reg_shift};
            CFG_ACCESS_WIDTH: prdata = {28'h0, r_access_width};
            default:          prdata = 32'h0;
        endcase
    end

endmodule
